// ===== hdl/i2cm_pkg.sv =====
// Shared types, codes and constants for the I2C master byte engine.
`timescale 1ns / 1ps

package i2cm_pkg;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    // Configuration register indexes.
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_RETRIES = 1'b1;

    localparam int HALF_PERIOD_W = 16;
    localparam int RETRIES_W     = 8;
    localparam int CFG_IDX_W     = 1;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 16'd10;
    localparam logic [RETRIES_W-1:0]     ACK_RETRIES_RST = 8'd5;

    // Phase numbers of the write and read sequences.
    localparam logic [6:0] PH_START_LAST = 7'd3;
    localparam logic [6:0] W_BITS_END    = 7'd32;
    localparam logic [6:0] W_RELEASE     = 7'd33;
    localparam logic [6:0] W_ACK_HIGH    = 7'd34;
    localparam logic [6:0] W_RETRY       = 7'd35;
    localparam logic [6:0] W_ACK_OK      = 7'd36;
    localparam logic [6:0] W_ERR_STOP    = 7'd37;
    localparam logic [6:0] W_ERR_SCL_LO  = 7'd38;
    localparam logic [6:0] W_ERR_SDA_LO  = 7'd39;
    localparam logic [6:0] W_ERR_SCL_HI  = 7'd40;
    localparam logic [6:0] W_LAST        = 7'd41;
    localparam logic [6:0] R_LAST_BIT    = 7'd23;
    localparam logic [6:0] R_ACK_SCL_LO  = 7'd24;
    localparam logic [6:0] R_ACK_DRIVE   = 7'd25;
    localparam logic [6:0] R_ACK_SCL_HI  = 7'd27;
    localparam logic [6:0] R_LAST        = 7'd28;

    // Bit k of MOD3_ZERO is set when k mod 3 is zero, of MOD3_TWO when it is two, for k below 32.
    localparam logic [31:0] MOD3_ZERO = 32'h4924_9249;
    localparam logic [31:0] MOD3_TWO  = 32'h2492_4924;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       master_ack;
        logic       sda_in;
    } t_tick_in;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } t_tick_res;

endpackage

// ===== hdl/i2cm_tick_if.sv =====
// Valid/ready channel interfaces for the tick words and the result words.
`timescale 1ns / 1ps

interface i2cm_tick_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       master_ack;
    logic       sda_in;

    modport source (output valid, action, tx_byte, master_ack, sda_in, input ready);
    modport sink (input valid, action, tx_byte, master_ack, sda_in, output ready);
endinterface

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;

    modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    rx_byte, ack_error, input ready);
    modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, ack_error, output ready);
endinterface

// ===== hdl/i2cm_engine.sv =====
// Bus phase sequencer: configuration, command state and the per-tick update.
`timescale 1ns / 1ps

module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [HALF_PERIOD_W-1:0] i_cfg_data,
    input  logic                     i_step,
    input  t_tick_in                 i_tick,
    output t_tick_res                o_next
);

    logic [HALF_PERIOD_W-1:0] r_half_period;
    logic [RETRIES_W-1:0]     r_ack_retries;

    t_op         r_op, n_op;
    logic [6:0]  r_phase, n_phase;
    logic [15:0] r_tick, n_tick;
    logic [7:0]  r_shift, n_shift;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_retry, n_retry;
    logic        r_ack, n_ack;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_drive, n_drive;
    logic        r_err, n_err;
    logic [7:0]  r_rx, n_rx;

    logic        done;
    logic        enter;
    logic [15:0] hp;
    logic [16:0] tick_sum;
    logic [7:0]  lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_ack_retries <= ACK_RETRIES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HALF_PERIOD: r_half_period <= i_cfg_data;
                REG_ACK_RETRIES: r_ack_retries <= i_cfg_data[RETRIES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= OP_NONE;
            r_phase <= '0;
            r_tick  <= '0;
            r_shift <= '0;
            r_bit   <= '0;
            r_retry <= '0;
            r_ack   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_drive <= 1'b1;
            r_err   <= 1'b0;
            r_rx    <= '0;
        end else if (i_step) begin
            r_op    <= n_op;
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_shift <= n_shift;
            r_bit   <= n_bit;
            r_retry <= n_retry;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_drive <= n_drive;
            r_err   <= n_err;
            r_rx    <= n_rx;
        end
    end

    always_comb begin
        n_op     = r_op;
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_shift  = r_shift;
        n_bit    = r_bit;
        n_retry  = r_retry;
        n_ack    = r_ack;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_drive  = r_drive;
        n_err    = r_err;
        n_rx     = r_rx;
        done     = 1'b0;
        enter    = 1'b0;
        hp       = (r_half_period == '0) ? 16'd1 : r_half_period;
        lim      = (r_ack_retries == '0) ? 8'd1 : r_ack_retries;
        tick_sum = {1'b0, r_tick} + 17'd1;

        if (r_op == OP_NONE) begin
            case (i_tick.action)
                OP_START, OP_STOP, OP_WRITE, OP_READ: begin
                    n_op    = t_op'(i_tick.action);
                    n_phase = '0;
                    n_tick  = '0;
                    n_retry = '0;
                    n_bit   = '0;
                    if (i_tick.action == OP_WRITE) begin
                        n_shift = i_tick.tx_byte;
                        n_err   = 1'b0;
                    end
                    if (i_tick.action == OP_READ) begin
                        n_shift = '0;
                        n_ack   = i_tick.master_ack;
                    end
                    enter = 1'b1;
                end
                default: ;
            endcase
        end else if (tick_sum >= {1'b0, hp}) begin
            // End of the running phase.
            n_tick = '0;
            unique case (r_op)
                OP_START, OP_STOP: begin
                    if (r_phase >= PH_START_LAST) begin
                        done = 1'b1;
                    end else begin
                        n_phase = r_phase + 7'd1;
                        enter   = 1'b1;
                    end
                end
                OP_WRITE: begin
                    if (r_phase < W_ACK_HIGH) begin
                        if (r_phase < W_BITS_END && r_phase[1:0] == 2'd3) begin
                            n_bit = r_bit + 4'd1;
                        end
                        n_phase = r_phase + 7'd1;
                        enter   = 1'b1;
                    end else if (r_phase == W_ACK_HIGH || r_phase == W_RETRY) begin
                        if (r_phase == W_RETRY && r_retry >= lim) begin
                            n_err   = 1'b1;
                            n_phase = W_ERR_STOP;
                            enter   = 1'b1;
                        end else if (!i_tick.sda_in) begin
                            n_phase = W_ACK_OK;
                            enter   = 1'b1;
                        end else begin
                            n_retry = r_retry + 8'd1;
                            n_phase = W_RETRY;
                        end
                    end else if (r_phase == W_ACK_OK) begin
                        n_drive = 1'b1;
                        n_sda   = 1'b1;
                        done    = 1'b1;
                    end else if (r_phase >= W_LAST) begin
                        done = 1'b1;
                    end else begin
                        n_phase = r_phase + 7'd1;
                        enter   = 1'b1;
                    end
                end
                OP_READ: begin
                    if (r_phase <= R_LAST_BIT && MOD3_TWO[r_phase[4:0]]) begin
                        n_shift = {r_shift[6:0], i_tick.sda_in};
                        n_bit   = r_bit + 4'd1;
                        if (r_phase == R_LAST_BIT) begin
                            n_rx = {r_shift[6:0], i_tick.sda_in};
                        end
                    end
                    if (r_phase >= R_LAST) begin
                        done = 1'b1;
                    end else begin
                        n_phase = r_phase + 7'd1;
                        enter   = 1'b1;
                    end
                end
                default: done = 1'b1;
            endcase
            if (done) begin
                n_op    = OP_NONE;
                n_phase = '0;
            end
        end else begin
            n_tick = tick_sum[15:0];
        end

        // Pin changes made as a new phase begins.
        if (enter) begin
            unique case (n_op)
                OP_START: begin
                    if (n_phase == 7'd0) begin
                        n_drive = 1'b1;
                        n_sda   = 1'b1;
                    end else if (n_phase == 7'd1) begin
                        n_scl = 1'b1;
                    end else if (n_phase == 7'd2) begin
                        n_sda = 1'b0;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                OP_STOP: begin
                    if (n_phase == 7'd0) begin
                        n_scl   = 1'b0;
                        n_drive = 1'b1;
                    end else if (n_phase == 7'd1) begin
                        n_sda = 1'b0;
                    end else if (n_phase == 7'd2) begin
                        n_scl = 1'b1;
                    end else begin
                        n_sda = 1'b1;
                    end
                end
                OP_WRITE: begin
                    if (n_phase < W_BITS_END) begin
                        case (n_phase[1:0])
                            2'd0: begin
                                n_scl   = 1'b0;
                                n_drive = 1'b1;
                            end
                            2'd1: n_sda = n_shift[7];
                            2'd2: n_shift = {n_shift[6:0], 1'b0};
                            default: n_scl = 1'b1;
                        endcase
                    end else if (n_phase == W_BITS_END) begin
                        n_scl = 1'b0;
                    end else if (n_phase == W_RELEASE) begin
                        n_drive = 1'b0;
                        n_sda   = 1'b1;
                    end else if (n_phase == W_ACK_HIGH) begin
                        n_scl = 1'b1;
                    end else if (n_phase == W_ACK_OK) begin
                        n_scl = 1'b0;
                    end else if (n_phase == W_ERR_STOP) begin
                        n_drive = 1'b1;
                        n_sda   = 1'b1;
                    end else if (n_phase == W_ERR_SCL_LO) begin
                        n_scl = 1'b0;
                    end else if (n_phase == W_ERR_SDA_LO) begin
                        n_sda = 1'b0;
                    end else if (n_phase == W_ERR_SCL_HI) begin
                        n_scl = 1'b1;
                    end else if (n_phase == W_LAST) begin
                        n_sda = 1'b1;
                    end
                end
                OP_READ: begin
                    if (n_phase == 7'd0) begin
                        n_drive = 1'b0;
                        n_sda   = 1'b1;
                        n_scl   = 1'b0;
                    end else if (n_phase <= R_LAST_BIT) begin
                        if (MOD3_ZERO[n_phase[4:0]]) begin
                            n_scl = 1'b0;
                        end else if (MOD3_TWO[n_phase[4:0]]) begin
                            n_scl = 1'b1;
                        end
                    end else if (n_phase == R_ACK_SCL_LO) begin
                        n_scl = 1'b0;
                    end else if (n_phase == R_ACK_DRIVE) begin
                        n_drive = 1'b1;
                        n_sda   = ~n_ack;
                    end else if (n_phase == R_ACK_SCL_HI) begin
                        n_scl = 1'b1;
                    end else if (n_phase == R_LAST) begin
                        n_scl = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        o_next.scl_level = n_scl;
        o_next.sda_level = n_sda;
        o_next.sda_drive = n_drive;
        o_next.busy_res  = (n_op != OP_NONE);
        o_next.done_res  = done;
        o_next.rx_byte   = n_rx;
        o_next.ack_error = n_err;
    end

endmodule

// ===== hdl/i2c_master_byte_engine_core.sv =====
// Top level of the I2C master byte engine: channels, output register and engine.
`timescale 1ns / 1ps

// Each input word is one tick of bus timing. It may carry a command (start, stop,
// write byte, read byte), taken only while the engine is idle, plus the sampled
// SDA level. Each accepted word yields exactly one result word on o_res with the
// SCL and SDA drive levels, busy, a one-tick done pulse, the last read byte and
// the acknowledge error flag, all as they stand after that tick.
// The result of a tick sits in the output register on the cycle after the tick is
// accepted. Throughput is one word per cycle while the receiver takes each result;
// the whole tick update is a single pass of logic between the state registers and the
// output register.
// If the receiver stalls, the output register holds its word and i_tick.ready
// drops until the word is taken, so no tick is lost and bus timing simply pauses.
// Configuration: i_cfg_idx 0 sets ticks per bus phase, 1 sets acknowledge retries.
// Reset (synchronous, active low) returns the engine to idle with SCL and SDA
// driven high, restores the default register values and empties the output.
module i2c_master_byte_engine_core
    import i2cm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [HALF_PERIOD_W-1:0] i_cfg_data,
    i2cm_tick_if.sink                i_tick,
    i2cm_res_if.source               o_res
);

    logic      r_out_valid;
    t_tick_res r_out;
    t_tick_res next_res;
    t_tick_in  tick_word;
    logic      step;

    assign i_tick.ready = !r_out_valid || o_res.ready;
    assign step         = i_tick.valid && i_tick.ready;

    assign tick_word.action     = i_tick.action;
    assign tick_word.tx_byte    = i_tick.tx_byte;
    assign tick_word.master_ack = i_tick.master_ack;
    assign tick_word.sda_in     = i_tick.sda_in;

    i2cm_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_step    (step),
        .i_tick    (tick_word),
        .o_next    (next_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= next_res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.scl_level = r_out.scl_level;
    assign o_res.sda_level = r_out.sda_level;
    assign o_res.sda_drive = r_out.sda_drive;
    assign o_res.busy_res  = r_out.busy_res;
    assign o_res.done_res  = r_out.done_res;
    assign o_res.rx_byte   = r_out.rx_byte;
    assign o_res.ack_error = r_out.ack_error;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the I2C master byte engine with tick and result channels.
`timescale 1ns / 1ps

module tb_top;
    import i2cm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          LONG_HOLD   = 300;
    localparam int          PHASE_TICKS = 20;
    localparam logic [2:0]  ACT_UNUSED_MIN = 3'd5;

    typedef enum {LINE_LOW, LINE_HIGH, LINE_RAND} t_line_mode;

    typedef struct {
        logic [6:0]  step;
        int unsigned ticks;
        logic [7:0]  shreg;
        logic [7:0]  retry;
        t_op         op;
        logic        ack_sel;
        logic        scl;
        logic        sda;
        logic        drv;
        logic        err;
        logic [7:0]  rx;
        logic        done;
    } t_bus_state;

    typedef struct {
        logic [HALF_PERIOD_W-1:0] half_period;
        logic [RETRIES_W-1:0]     ack_retries;
    } t_reg_file;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_idx;
    logic [HALF_PERIOD_W-1:0] cfg_data;

    i2cm_tick_if tick_ch ();
    i2cm_res_if  res_ch ();

    i2c_master_byte_engine_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_tick     (tick_ch),
        .o_res      (res_ch)
    );

    // The generator keeps its own copy of the engine so it knows when a command is done.
    t_bus_state  gen_bus;
    t_reg_file   gen_cfg;
    t_bus_state  chk_bus;
    t_reg_file   chk_cfg;

    t_tick_in    pending_ticks[$];
    t_tick_res   expected_words[$];
    int          ticks_made;
    int          fail_count;
    int unsigned cycle_count;
    int          hold_req;

    int send_gap;
    int send_calm;
    int rx_wait;
    int rx_calm;
    int hold_seen;

    function automatic t_bus_state bus_idle();
        t_bus_state s;
        s.step    = '0;
        s.ticks   = 0;
        s.shreg   = '0;
        s.retry   = '0;
        s.op      = OP_NONE;
        s.ack_sel = 1'b0;
        s.scl     = 1'b1;
        s.sda     = 1'b1;
        s.drv     = 1'b1;
        s.err     = 1'b0;
        s.rx      = '0;
        s.done    = 1'b0;
        return s;
    endfunction

    // Pin changes made on entry to the current phase.
    function automatic void set_phase_pins(inout t_bus_state s);
        logic [6:0] k;
        k = s.step;
        case (s.op)
            OP_START: begin
                if (k == 0) begin
                    s.drv = 1'b1;
                    s.sda = 1'b1;
                end else if (k == 1) s.scl = 1'b1;
                else if (k == 2) s.sda = 1'b0;
                else s.scl = 1'b0;
            end
            OP_STOP: begin
                if (k == 0) begin
                    s.scl = 1'b0;
                    s.drv = 1'b1;
                end else if (k == 1) s.sda = 1'b0;
                else if (k == 2) s.scl = 1'b1;
                else s.sda = 1'b1;
            end
            OP_WRITE: begin
                if (k < W_BITS_END) begin
                    case (k[1:0])
                        2'd0: begin
                            s.scl = 1'b0;
                            s.drv = 1'b1;
                        end
                        2'd1: s.sda = s.shreg[7];
                        2'd2: s.shreg = s.shreg << 1;
                        default: s.scl = 1'b1;
                    endcase
                end else if (k == W_BITS_END) s.scl = 1'b0;
                else if (k == W_RELEASE) begin
                    s.drv = 1'b0;
                    s.sda = 1'b1;
                end else if (k == W_ACK_HIGH) s.scl = 1'b1;
                else if (k == W_ACK_OK) s.scl = 1'b0;
                else if (k == W_ERR_STOP) begin
                    s.drv = 1'b1;
                    s.sda = 1'b1;
                end else if (k == W_ERR_SCL_LO) s.scl = 1'b0;
                else if (k == W_ERR_SDA_LO) s.sda = 1'b0;
                else if (k == W_ERR_SCL_HI) s.scl = 1'b1;
                else if (k == W_LAST) s.sda = 1'b1;
            end
            OP_READ: begin
                if (k == 0) begin
                    s.drv = 1'b0;
                    s.sda = 1'b1;
                    s.scl = 1'b0;
                end else if (k <= R_LAST_BIT) begin
                    if (k % 3 == 0) s.scl = 1'b0;
                    else if (k % 3 == 2) s.scl = 1'b1;
                end else if (k == R_ACK_SCL_LO) s.scl = 1'b0;
                else if (k == R_ACK_DRIVE) begin
                    s.drv = 1'b1;
                    s.sda = !s.ack_sel;
                end else if (k == R_ACK_SCL_HI) s.scl = 1'b1;
                else if (k == R_LAST) s.scl = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic void advance_phase(inout t_bus_state s);
        s.step = s.step + 7'd1;
        set_phase_pins(s);
    endfunction

    function automatic void close_cmd(inout t_bus_state s);
        s.op   = OP_NONE;
        s.step = '0;
        s.done = 1'b1;
    endfunction

    // Advances the engine by one tick and returns the word it should report.
    function automatic t_tick_res step_engine(inout t_bus_state s, input t_reg_file c,
                                              input t_tick_in w);
        t_tick_res   r;
        int unsigned hp;
        int unsigned lim;
        logic [6:0]  k;
        hp  = (c.half_period == 0) ? 1 : c.half_period;
        lim = (c.ack_retries == 0) ? 1 : c.ack_retries;
        s.done = 1'b0;
        if (s.op == OP_NONE) begin
            if (w.action >= OP_START && w.action <= OP_READ) begin
                s.op    = t_op'(w.action);
                s.step  = '0;
                s.ticks = 0;
                s.retry = '0;
                if (s.op == OP_WRITE) begin
                    s.shreg = w.tx_byte;
                    s.err   = 1'b0;
                end
                if (s.op == OP_READ) begin
                    s.shreg   = '0;
                    s.ack_sel = w.master_ack;
                end
                set_phase_pins(s);
            end
        end else begin
            s.ticks++;
            if (s.ticks >= hp) begin
                s.ticks = 0;
                k = s.step;
                case (s.op)
                    OP_START, OP_STOP: begin
                        if (k >= PH_START_LAST) close_cmd(s);
                        else advance_phase(s);
                    end
                    OP_WRITE: begin
                        if (k < W_ACK_HIGH) advance_phase(s);
                        else if (k == W_ACK_HIGH || k == W_RETRY) begin
                            // The retry budget is checked only once SDA has stayed high.
                            if (k == W_RETRY && s.retry >= lim) begin
                                s.err  = 1'b1;
                                s.step = W_ERR_STOP;
                                set_phase_pins(s);
                            end else if (!w.sda_in) begin
                                s.step = W_ACK_OK;
                                set_phase_pins(s);
                            end else begin
                                s.retry++;
                                s.step = W_RETRY;
                            end
                        end else if (k == W_ACK_OK) begin
                            s.drv = 1'b1;
                            s.sda = 1'b1;
                            close_cmd(s);
                        end else if (k >= W_LAST) close_cmd(s);
                        else advance_phase(s);
                    end
                    OP_READ: begin
                        if (k <= R_LAST_BIT && k % 3 == 2) begin
                            s.shreg = {s.shreg[6:0], w.sda_in};
                            if (k == R_LAST_BIT) s.rx = s.shreg;
                        end
                        if (k >= R_LAST) close_cmd(s);
                        else advance_phase(s);
                    end
                    default: close_cmd(s);
                endcase
            end
        end
        r.scl_level = s.scl;
        r.sda_level = s.sda;
        r.sda_drive = s.drv;
        r.busy_res  = (s.op != OP_NONE);
        r.done_res  = s.done;
        r.rx_byte   = s.rx;
        r.ack_error = s.err;
        return r;
    endfunction

    function automatic int draw_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            calm = $urandom_range(20, 100);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic queue_tick(logic [2:0] act, logic [7:0] tx, logic mack, logic sda);
        t_tick_in w;
        w.action     = act;
        w.tx_byte    = tx;
        w.master_ack = mack;
        w.sda_in     = sda;
        void'(step_engine(gen_bus, gen_cfg, w));
        pending_ticks.push_back(w);
        ticks_made++;
    endtask

    // Busy ticks carry stray commands now and then; the engine must ignore them.
    task automatic queue_until_idle(t_line_mode m);
        logic [2:0] act;
        logic       sda;
        while (gen_bus.op != OP_NONE) begin
            act = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : OP_NONE;
            if (m == LINE_LOW) sda = 1'b0;
            else if (m == LINE_HIGH) sda = 1'b1;
            else sda = ($urandom_range(0, 2) != 0);
            queue_tick(act, 8'($urandom), 1'($urandom), sda);
        end
    endtask

    task automatic run_cmd(t_op op, logic [7:0] tx, logic mack, t_line_mode m);
        queue_tick(op, tx, mack, 1'($urandom));
        queue_until_idle(m);
    endtask

    task automatic queue_ignored();
        logic [2:0] act;
        act = ($urandom_range(0, 3) == 0) ? OP_NONE : ACT_UNUSED_MIN + 3'($urandom_range(0, 2));
        queue_tick(act, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        while (pending_ticks.size() != 0 || tick_ch.valid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [HALF_PERIOD_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_HALF_PERIOD) begin
            gen_cfg.half_period = val;
            chk_cfg.half_period = val;
        end else begin
            gen_cfg.ack_retries = val[RETRIES_W-1:0];
            chk_cfg.ack_retries = val[RETRIES_W-1:0];
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Tick driver: a new word goes out only once the previous one has been taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_ch.valid <= 1'b0;
        end else if (!tick_ch.valid || tick_ch.ready) begin
            if (send_gap > 0) begin
                send_gap--;
                tick_ch.valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                t_tick_in w;
                w = pending_ticks.pop_front();
                tick_ch.valid      <= 1'b1;
                tick_ch.action     <= w.action;
                tick_ch.tx_byte    <= w.tx_byte;
                tick_ch.master_ack <= w.master_ack;
                tick_ch.sda_in     <= w.sda_in;
                send_gap = draw_idle(send_calm);
            end else begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                rx_wait   = LONG_HOLD;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                rx_wait = draw_idle(rx_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word arrived with no tick waiting for it");
                    fail_count++;
                end else begin
                    t_tick_res want;
                    want = expected_words.pop_front();
                    check_field("scl_level", 8'(want.scl_level), 8'(res_ch.scl_level));
                    check_field("sda_level", 8'(want.sda_level), 8'(res_ch.sda_level));
                    check_field("sda_drive", 8'(want.sda_drive), 8'(res_ch.sda_drive));
                    check_field("busy_res",  8'(want.busy_res),  8'(res_ch.busy_res));
                    check_field("done_res",  8'(want.done_res),  8'(res_ch.done_res));
                    check_field("rx_byte",   want.rx_byte,       res_ch.rx_byte);
                    check_field("ack_error", 8'(want.ack_error), 8'(res_ch.ack_error));
                end
            end
            if (tick_ch.valid && tick_ch.ready) begin
                t_tick_in w;
                w.action     = tick_ch.action;
                w.tx_byte    = tick_ch.tx_byte;
                w.master_ack = tick_ch.master_ack;
                w.sda_in     = tick_ch.sda_in;
                expected_words.push_back(step_engine(chk_bus, chk_cfg, w));
            end
        end
    end

    initial begin
        int mark;
        int r;
        t_line_mode m;
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = REG_HALF_PERIOD;
        cfg_data           = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.action     = OP_NONE;
        tick_ch.tx_byte    = '0;
        tick_ch.master_ack = 1'b0;
        tick_ch.sda_in     = 1'b1;
        res_ch.ready       = 1'b0;
        gen_bus            = bus_idle();
        chk_bus            = bus_idle();
        gen_cfg.half_period = HALF_PERIOD_RST;
        gen_cfg.ack_retries = ACK_RETRIES_RST;
        chk_cfg            = gen_cfg;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Power-up register values.
        run_cmd(OP_START, 8'h00, 1'b0, LINE_RAND);
        run_cmd(OP_STOP, 8'hFF, 1'b1, LINE_RAND);
        drain();

        write_reg(REG_HALF_PERIOD, 16'd1);
        write_reg(REG_ACK_RETRIES, 16'd1);
        run_cmd(OP_START, 8'h00, 1'b0, LINE_RAND);
        run_cmd(OP_WRITE, 8'hFF, 1'b1, LINE_LOW);
        run_cmd(OP_WRITE, 8'h00, 1'b0, LINE_HIGH);
        run_cmd(OP_READ, 8'h00, 1'b1, LINE_HIGH);
        run_cmd(OP_READ, 8'hFF, 1'b0, LINE_LOW);
        run_cmd(OP_READ, 8'hA5, 1'b1, LINE_RAND);
        for (int j = 0; j < 3; j++)
            queue_tick(ACT_UNUSED_MIN + 3'(j), 8'($urandom), 1'($urandom), 1'($urandom));
        run_cmd(OP_STOP, 8'h00, 1'b0, LINE_RAND);
        drain();

        // Zero in either register behaves as one.
        write_reg(REG_HALF_PERIOD, 16'd0);
        write_reg(REG_ACK_RETRIES, {8'($urandom), 8'd0});
        run_cmd(OP_WRITE, 8'h5A, 1'b0, LINE_HIGH);
        run_cmd(OP_READ, 8'($urandom), 1'b1, LINE_RAND);
        drain();

        // A very long phase is cut short by lowering the half period mid-command.
        write_reg(REG_HALF_PERIOD, 16'hFFFF);
        write_reg(REG_ACK_RETRIES, {8'($urandom), 8'hFF});
        queue_tick(OP_START, 8'($urandom), 1'($urandom), 1'($urandom));
        repeat (12) queue_tick(OP_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
        drain();
        write_reg(REG_HALF_PERIOD, 16'd1);
        queue_until_idle(LINE_RAND);
        run_cmd(OP_WRITE, 8'($urandom), 1'b0, LINE_HIGH);
        run_cmd(OP_WRITE, 8'($urandom), 1'b1, LINE_RAND);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            write_reg(REG_HALF_PERIOD, 16'($urandom_range(1, 3)));
            write_reg(REG_ACK_RETRIES, 16'($urandom_range(1, 6)));
            mark = ticks_made;
            while (ticks_made - mark < PHASE_TICKS) begin
                if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) queue_ignored();
                r = $urandom_range(0, 9);
                m = (r == 0) ? LINE_LOW : (r < 3) ? LINE_HIGH : LINE_RAND;
                r = $urandom_range(0, 19);
                if (r < 8) run_cmd(OP_WRITE, 8'($urandom), 1'($urandom), m);
                else if (r < 14) run_cmd(OP_READ, 8'($urandom), 1'($urandom), m);
                else if (r < 17) run_cmd(OP_START, 8'($urandom), 1'($urandom), m);
                else run_cmd(OP_STOP, 8'($urandom), 1'($urandom), m);
            end
            // Let the result side stall long enough for the block to back up its input.
            if (ph == 1) hold_req++;
        end
        drain();

        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/i2cm_pkg.sv
hdl/i2cm_tick_if.sv
hdl/i2cm_engine.sv
hdl/i2c_master_byte_engine_core.sv
tb/tb_top.sv
